@@ rtl/oaathb_pkg.sv @@
// Shared types, constants and hash step functions for the one-at-a-time hash bucket block.
// No dependencies.
package oaathb_pkg;

  localparam int unsigned HashW     = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned DataW     = 32;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);
  localparam int unsigned DivSteps  = HashW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  localparam logic [HashW-1:0] BucketCountReset = 32'd23;
  localparam logic             RegBucketCount   = 1'b0;

  typedef struct packed {
    logic [ByteW-1:0] key_byte;
    logic             has_byte;
    logic             last_byte;
  } in_t;

  typedef struct packed {
    logic [HashW-1:0] hash_value;
    logic [HashW-1:0] bucket_index;
  } out_t;

  function automatic logic [HashW-1:0] mix_byte(input logic [HashW-1:0] h,
                                                input logic [ByteW-1:0] b);
    logic [HashW-1:0] h1;
    logic [HashW-1:0] h2;
    h1 = h + {{(HashW-ByteW){1'b0}}, b};
    h2 = h1 + (h1 << 10);
    return h2 ^ (h2 >> 6);
  endfunction

  function automatic logic [HashW-1:0] finish_a(input logic [HashW-1:0] h);
    logic [HashW-1:0] h1;
    h1 = h + (h << 3);
    return h1 ^ (h1 >> 11);
  endfunction

  function automatic logic [HashW-1:0] finish_b(input logic [HashW-1:0] h);
    return h + (h << 15);
  endfunction

endpackage

@@ rtl/oaathb_fifo.sv @@
// Short queue of running hash values between front and back.
// Depends on oaathb_pkg.
module oaathb_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_i,
  input  logic [oaathb_pkg::HashW-1:0] wdata_i,
  output logic                        full_o,
  input  logic                        rd_i,
  output logic [oaathb_pkg::HashW-1:0] rdata_o,
  output logic                        empty_o
);

  logic [oaathb_pkg::HashW-1:0] mem_q [oaathb_pkg::QDepth];
  logic [oaathb_pkg::QPtrW-1:0] wptr_q, rptr_q;
  logic [oaathb_pkg::QCntW-1:0] cnt_q;
  logic                         do_wr, do_rd;

  assign full_o  = (cnt_q == oaathb_pkg::QCntW'(oaathb_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == oaathb_pkg::QPtrW'(oaathb_pkg::QDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == oaathb_pkg::QPtrW'(oaathb_pkg::QDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/oaathb_front.sv @@
// Front end: accepts key bytes and folds them into the running hash.
// Depends on oaathb_pkg; pushes finished keys into oaathb_fifo.
module oaathb_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  oaathb_pkg::in_t              in_data_i,
  input  logic                         q_full_i,
  output logic                         q_wr_o,
  output logic [oaathb_pkg::HashW-1:0] q_wdata_o
);

  logic [oaathb_pkg::HashW-1:0] hash_q, hash_d, mixed;
  logic                         accept;

  assign accept    = push_i && !q_full_i;
  assign mixed     = in_data_i.has_byte ? oaathb_pkg::mix_byte(hash_q, in_data_i.key_byte)
                                        : hash_q;
  assign q_wr_o    = accept && in_data_i.last_byte;
  assign q_wdata_o = mixed;

  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      hash_d = in_data_i.last_byte ? '0 : mixed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

@@ rtl/oaathb_back.sv @@
// Back end: finalizes a key's hash, reduces it modulo the bucket count, holds the result.
// Depends on oaathb_pkg; pops keys from oaathb_fifo.
module oaathb_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  logic [oaathb_pkg::HashW-1:0] q_rdata_i,
  output logic                         q_rd_o,
  input  logic [oaathb_pkg::HashW-1:0] bucket_count_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output oaathb_pkg::out_t             out_data_o
);

  typedef enum logic [2:0] {IdleS, Fin1S, Fin2S, DivS, DoneS} state_e;

  state_e                         state_q;
  logic [oaathb_pkg::HashW-1:0]   h_q, dvd_q, rem_q, div_q;
  logic [oaathb_pkg::DivCntW-1:0] cnt_q;
  logic                           out_valid_q;
  oaathb_pkg::out_t               out_q;
  logic [oaathb_pkg::HashW:0]     trial;
  logic [oaathb_pkg::HashW:0]     diff;
  logic                           out_free;

  assign trial      = {rem_q, dvd_q[oaathb_pkg::HashW-1]};
  assign diff       = trial - {1'b0, div_q};
  assign out_free   = !out_valid_q || pop_i;
  assign q_rd_o     = (state_q == IdleS) && !q_empty_i;
  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IdleS;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      h_q         <= '0;
      dvd_q       <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      out_q       <= '0;
    end else begin
      if (state_q == DoneS && out_free) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        IdleS: begin
          if (!q_empty_i) begin
            h_q     <= q_rdata_i;
            state_q <= Fin1S;
          end
        end
        Fin1S: begin
          h_q     <= oaathb_pkg::finish_a(h_q);
          state_q <= Fin2S;
        end
        Fin2S: begin
          h_q     <= oaathb_pkg::finish_b(h_q);
          dvd_q   <= oaathb_pkg::finish_b(h_q);
          rem_q   <= '0;
          div_q   <= bucket_count_i;
          cnt_q   <= '0;
          state_q <= DivS;
        end
        DivS: begin
          rem_q <= diff[oaathb_pkg::HashW] ? trial[oaathb_pkg::HashW-1:0]
                                           : diff[oaathb_pkg::HashW-1:0];
          dvd_q <= dvd_q << 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == oaathb_pkg::DivCntW'(oaathb_pkg::DivSteps - 1)) begin
            state_q <= DoneS;
          end
        end
        DoneS: begin
          if (out_free) begin
            out_q.hash_value   <= h_q;
            out_q.bucket_index <= (div_q == '0) ? '0 : rem_q;
            state_q            <= IdleS;
          end
        end
        default: begin
          state_q <= IdleS;
        end
      endcase
    end
  end

endmodule

@@ rtl/one_at_a_time_hash_bucket.sv @@
// One-at-a-time hash with bucket selection: top level, APB register and queue wiring.
// Depends on oaathb_pkg, oaathb_front, oaathb_fifo, oaathb_back.
// Throughput: one key byte per cycle while the queue is not full; the back end's bit-serial
// remainder unit takes one key at a time (pop, Fin1S, Fin2S, 32 divide steps, store).
// A key's last byte enters the queue, then the back end pops, finalizes and reduces it.
// Reset: running hash cleared to zero, bucket_count to 23, queue and result emptied.
module one_at_a_time_hash_bucket (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [oaathb_pkg::AddrW-1:0]        paddr,
  input  logic [oaathb_pkg::DataW-1:0]        pwdata,
  output logic [oaathb_pkg::DataW-1:0]        prdata,
  output logic                                pready,
  input  logic                                push,
  output logic                                full,
  input  oaathb_pkg::in_t                     in_data_i,
  output logic                                empty,
  input  logic                                pop,
  output oaathb_pkg::out_t                    out_data_o
);

  logic [oaathb_pkg::HashW-1:0] bucket_count_q;
  logic                         q_wr, q_rd, q_full, q_empty;
  logic [oaathb_pkg::HashW-1:0] q_wdata, q_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[oaathb_pkg::AddrW-1] == oaathb_pkg::RegBucketCount) ? bucket_count_q
                                                                              : '0;
  assign full   = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= oaathb_pkg::BucketCountReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[oaathb_pkg::AddrW-1] == oaathb_pkg::RegBucketCount) begin
      bucket_count_q <= pwdata;
    end
  end

  oaathb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .q_wr_o    (q_wr),
    .q_wdata_o (q_wdata)
  );

  oaathb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  oaathb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_rdata_i      (q_rdata),
    .q_rd_o         (q_rd),
    .bucket_count_i (bucket_count_q),
    .empty_o        (empty),
    .pop_i          (pop),
    .out_data_o     (out_data_o)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for one_at_a_time_hash_bucket: keys stream in as byte beats, hashes and
// bucket indexes are predicted on accept and checked on pop, across several bucket counts.
// Depends on oaathb_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
  import oaathb_pkg::*;

  localparam logic [AddrW-1:0] BucketCountAddr = {RegBucketCount, 2'b00};
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SettleCycles = 45;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             push = 1'b0;
  logic             full;
  in_t              in_data = '0;
  logic             empty;
  logic             pop = 1'b0;
  out_t             out_data;

  in_t              key_beat_q[$];
  out_t             hash_bucket_q[$];
  logic [HashW-1:0] key_acc = '0;
  logic [HashW-1:0] bucket_cfg = BucketCountReset;
  logic [HashW-1:0] bucket_plan[7];
  int unsigned      mismatches = 0;
  int unsigned      burst_left;
  int unsigned      gap_left;
  int unsigned      hold_left;
  logic [5:0]       rx_cycles;
  logic [1:0]       rx_mode;
  logic             hold_kick = 1'b0;
  out_t             want;

  one_at_a_time_hash_bucket i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [HashW-1:0] oaat_fold(input logic [HashW-1:0] acc,
                                                 input logic [ByteW-1:0] b);
    logic [HashW-1:0] t;
    t = acc + HashW'(b);
    t = t + {t[HashW-11:0], 10'b0};
    return t ^ {6'b0, t[HashW-1:6]};
  endfunction

  function automatic logic [HashW-1:0] oaat_avalanche(input logic [HashW-1:0] acc);
    logic [HashW-1:0] t;
    t = acc + {acc[HashW-4:0], 3'b0};
    t = t ^ {11'b0, t[HashW-1:11]};
    return t + {t[HashW-16:0], 15'b0};
  endfunction

  task automatic track_key_beat(input in_t beat);
    out_t res;
    if (beat.has_byte) key_acc = oaat_fold(key_acc, beat.key_byte);
    if (beat.last_byte) begin
      res.hash_value = oaat_avalanche(key_acc);
      res.bucket_index = (bucket_cfg != '0) ? res.hash_value % bucket_cfg : '0;
      hash_bucket_q.push_back(res);
      key_acc = '0;
    end
  endtask

  function automatic void add_beat(input logic [ByteW-1:0] b, input logic has,
                                   input logic last);
    in_t beat;
    beat.key_byte = b;
    beat.has_byte = has;
    beat.last_byte = last;
    key_beat_q.push_back(beat);
  endfunction

  task automatic queue_random_keys(input int unsigned n_items);
    int unsigned made;
    int unsigned len;
    int unsigned pick;
    logic        empty_end;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) len = 0;
      else if (pick == 1) len = $urandom_range(9, 40);
      else len = $urandom_range(1, 8);
      empty_end = ($urandom_range(0, 5) == 0);
      for (int unsigned k = 0; k < len; k++) begin
        if ($urandom_range(0, 15) == 0) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        add_beat(8'($urandom_range(0, 255)), 1'b1, (k == len - 1) && !empty_end);
      end
      if (len == 0 || empty_end) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      made += len + ((len == 0 || empty_end) ? 1 : 0);
    end
  endtask

  task automatic cfg_check(input logic [DataW-1:0] want_val);
    logic [DataW-1:0] rd;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= BucketCountAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    rd = prdata;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== want_val) begin
      $display("%0t: bucket_count read expected %h got %h", $time, want_val, rd);
      mismatches++;
    end
  endtask

  task automatic cfg_write(input logic [DataW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= BucketCountAddr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    bucket_cfg = value;
    cfg_check(value);
  endtask

  task automatic drain_block();
    do @(negedge clk_i); while (key_beat_q.size() != 0 || push);
    while (hash_bucket_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // sender: bursts of beats with random gaps, hold the beat while full
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (push && !full) track_key_beat(in_data);
      if (!(push && full)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          push <= 1'b0;
        end else if (key_beat_q.size() != 0) begin
          push <= 1'b1;
          in_data <= key_beat_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: check each popped beat, stall by mode, long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      hold_left <= 0;
      rx_cycles <= '0;
      rx_mode <= '0;
    end else begin
      if (pop && !empty) begin
        if (hash_bucket_q.size() == 0) begin
          $display("%0t: result expected none got hash %h bucket %h", $time,
                   out_data.hash_value, out_data.bucket_index);
          mismatches++;
        end else begin
          want = hash_bucket_q.pop_front();
          if (out_data.hash_value !== want.hash_value) begin
            $display("%0t: hash_value expected %h got %h", $time, want.hash_value,
                     out_data.hash_value);
            mismatches++;
          end
          if (out_data.bucket_index !== want.bucket_index) begin
            $display("%0t: bucket_index expected %h got %h", $time, want.bucket_index,
                     out_data.bucket_index);
            mismatches++;
          end
        end
      end
      rx_cycles <= rx_cycles + 1'b1;
      if (rx_cycles == '0) rx_mode <= 2'($urandom_range(0, 3));
      if (hold_kick) begin
        hold_left <= HoldCycles;
        pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        case (rx_mode)
          2'd0: pop <= 1'b1;
          2'd1: pop <= ($urandom_range(0, 1) == 0);
          2'd2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    bucket_plan[0] = 32'd1;
    bucket_plan[1] = 32'hFFFF_FFFF;
    bucket_plan[2] = 32'd0;
    bucket_plan[3] = 32'd2;
    bucket_plan[4] = 32'h8000_0000;
    bucket_plan[5] = $urandom_range(3, 5000);
    bucket_plan[6] = $urandom();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cfg_check(BucketCountReset);

    add_beat(8'hFF, 1'b0, 1'b1);
    add_beat(8'h00, 1'b1, 1'b1);
    add_beat(8'hFF, 1'b1, 1'b1);
    add_beat(8'hA5, 1'b0, 1'b0);
    add_beat(8'h61, 1'b1, 1'b0);
    add_beat(8'h62, 1'b1, 1'b0);
    add_beat(8'h5A, 1'b0, 1'b0);
    add_beat(8'h63, 1'b1, 1'b1);
    add_beat(8'h80, 1'b1, 1'b0);
    add_beat(8'h01, 1'b1, 1'b0);
    add_beat(8'h00, 1'b0, 1'b1);
    for (int k = 0; k < 8; k++) add_beat(8'hFF, 1'b1, k == 7);
    queue_random_keys(160);
    drain_block();

    for (int p = 0; p < 7; p++) begin
      cfg_write(bucket_plan[p]);
      queue_random_keys(160);
      if (p == 1) begin
        @(posedge clk_i);
        hold_kick <= 1'b1;
        @(posedge clk_i);
        hold_kick <= 1'b0;
      end
      drain_block();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/oaathb_pkg.sv
rtl/oaathb_fifo.sv
rtl/oaathb_front.sv
rtl/oaathb_back.sv
rtl/one_at_a_time_hash_bucket.sv
tb/tb_top.sv
